[rtl/ssqf_pkg.sv]
// Shared types and constants for the sensor sample qualifier and filter.
// Used by the channel interfaces and by every module of the block.
package ssqf_pkg;

  localparam int TEMP_W      = 15;
  localparam int HUMI_W      = 14;
  localparam int TSTEP_W     = 15;
  localparam int HSTEP_W     = 14;
  localparam int WORD_W      = 16;
  localparam int CHECK_W     = 8;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_STEP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HUMI_STEP = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_BUS,
    ST_TEMP_CRC,
    ST_HUMI_CRC,
    ST_TEMP_RANGE,
    ST_HUMI_RANGE,
    ST_TEMP_JUMP,
    ST_HUMI_JUMP
  } status_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_min;
    logic signed [TEMP_W-1:0] temp_max;
    logic [TSTEP_W-1:0]       temp_step_max;
    logic [HSTEP_W-1:0]       humi_step_max;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    temp_min:      -15'sd2500,
    temp_max:      15'sd3000,
    temp_step_max: 15'd500,
    humi_step_max: 14'd1000
  };

  typedef struct packed {
    status_t                  status;
    logic signed [TEMP_W-1:0] temp;
    logic [HUMI_W-1:0]        humi;
  } rec_t;

endpackage

[rtl/ssqf_if.sv]
// Valid/ready channel interfaces: sensor frame in, filtered result out, register writes.
// Depends on ssqf_pkg for field widths.
interface ssqf_in_if import ssqf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               bus_ok;
  logic [WORD_W-1:0]  temp_word;
  logic [CHECK_W-1:0] temp_check;
  logic [WORD_W-1:0]  humi_word;
  logic [CHECK_W-1:0] humi_check;

  modport source (output valid, bus_ok, temp_word, temp_check, humi_word, humi_check,
                  input ready);
  modport sink   (input valid, bus_ok, temp_word, temp_check, humi_word, humi_check,
                  output ready);
endinterface

interface ssqf_out_if import ssqf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  logic [HUMI_W-1:0]        humidity;
  logic [STATUS_W-1:0]      status;
  logic                     fresh;

  modport source (output valid, temperature, humidity, status, fresh, input ready);
  modport sink   (input valid, temperature, humidity, status, fresh, output ready);
endinterface

interface ssqf_cfg_if import ssqf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/ssqf_front.sv]
// Front end: takes a frame, checks both CRC bytes, converts to hundredths,
// compensates humidity and range-checks. Depends on ssqf_pkg and ssqf_in_if.
module ssqf_front import ssqf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ssqf_in_if.sink     in_ch,
  input  cfg_t        cfg,
  output logic        push_valid,
  input  logic        push_ready,
  output rec_t        push_rec
);

  localparam logic [7:0]  CRC_POLY   = 8'h31;
  localparam logic [7:0]  CRC_INIT   = 8'hFF;
  localparam int          NUM_W      = 39;
  localparam int          MAG_W      = 37;
  localparam logic [30:0] TEMP_GAIN  = 31'd17500;
  localparam logic [30:0] TEMP_OFS   = 31'd294907500;
  localparam logic [30:0] HUMI_GAIN  = 31'd12500;
  localparam logic signed [31:0] HUMI_OFS = 32'sd39321000;
  localparam logic signed [NUM_W-1:0] HUMI_X100 = 39'sd100;
  localparam logic signed [17:0] C_NEG  = 18'sd15;
  localparam logic signed [17:0] C_MID  = -18'sd3;
  localparam logic signed [17:0] KNEE18 = 18'sd2500;
  localparam logic signed [TEMP_W-1:0] KNEE15   = 15'sd2500;
  localparam logic signed [TEMP_W-1:0] HUMI_MAX = 15'sd10000;
  localparam logic [42:0] DIV100_MUL = 43'd2684355;

  typedef enum logic [3:0] {
    F_IDLE, F_HI, F_LO, F_COMP, F_HNUM, F_HMAG, F_HSUM, F_HQUO, F_HSCALE, F_PUSH
  } fstate_t;

  fstate_t state_r;

  logic               bus_ok_r;
  logic [WORD_W-1:0]  tw_r, hw_r;
  logic [CHECK_W-1:0] tc_r, hc_r;
  logic [7:0]         crc_t_r, crc_h_r;
  logic               tneg_r, hneg_r;
  logic [29:0]        tmag_r;
  logic signed [31:0] anum_r;
  logic signed [TEMP_W-1:0] t_r, h_r;
  logic signed [NUM_W-1:0]  p100_r, num_r;
  logic signed [17:0] c_r;
  logic [MAG_W-1:0]   hmag_r;
  logic [20:0]        ha_r, q1_r;
  logic [21:0]        hs_r;

  logic [30:0]        tprod, hprod;
  logic               tneg_c;
  logic [29:0]        tmag_c;
  logic [13:0]        ta;
  logic [16:0]        ts, s2;
  logic [14:0]        tq, q2;
  logic signed [31:0] anum_c;
  logic signed [17:0] t18, c_c;
  logic [NUM_W-1:0]   hmag_full;
  logic [5:0]         a2;
  logic               corr2;
  logic [20:0]        q1_c;
  logic [42:0]        prod100;
  status_t            st_c;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    crc = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
    end
    return crc;
  endfunction

  always_comb begin
    tprod  = 31'(tw_r) * TEMP_GAIN;
    tneg_c = tprod < TEMP_OFS;
    tmag_c = tneg_c ? 30'(TEMP_OFS - tprod) : 30'(tprod - TEMP_OFS);
    hprod  = 31'(hw_r) * HUMI_GAIN;
    anum_c = $signed({1'b0, hprod}) - HUMI_OFS;

    ta = tmag_r[29:16];
    ts = 17'(ta) + 17'(tmag_r[15:0]);
    tq = 15'(ta) + 15'(ts >= 17'd65535);

    t18 = 18'(t_r);
    if (t_r < 15'sd0) begin
      c_c = t18 * C_NEG;
    end else if (t_r < KNEE15) begin
      c_c = t18 * C_MID;
    end else begin
      c_c = (t18 - KNEE18) <<< 3;
    end

    hmag_full = num_r[NUM_W-1] ? -num_r : num_r;

    a2    = hs_r[21:16];
    s2    = 17'(a2) + 17'(hs_r[15:0]);
    corr2 = s2 >= 17'd65535;
    q1_c  = ha_r + 21'(a2) + 21'(corr2);

    prod100 = 43'(q1_r) * DIV100_MUL;
    q2      = prod100[42:28];

    if (!bus_ok_r) begin
      st_c = ST_BUS;
    end else if (crc_t_r != tc_r) begin
      st_c = ST_TEMP_CRC;
    end else if (crc_h_r != hc_r) begin
      st_c = ST_HUMI_CRC;
    end else if (t_r < cfg.temp_min || t_r > cfg.temp_max) begin
      st_c = ST_TEMP_RANGE;
    end else if (h_r < 15'sd0 || h_r > HUMI_MAX) begin
      st_c = ST_HUMI_RANGE;
    end else begin
      st_c = ST_OK;
    end
  end

  assign in_ch.ready = (state_r == F_IDLE);
  assign push_valid  = (state_r == F_PUSH);
  assign push_rec    = '{status: st_c, temp: t_r, humi: h_r[HUMI_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_ch.valid) begin
            bus_ok_r <= in_ch.bus_ok;
            tw_r     <= in_ch.temp_word;
            tc_r     <= in_ch.temp_check;
            hw_r     <= in_ch.humi_word;
            hc_r     <= in_ch.humi_check;
            state_r  <= F_HI;
          end
        end
        F_HI: begin
          crc_t_r <= crc8_byte(CRC_INIT, tw_r[15:8]);
          crc_h_r <= crc8_byte(CRC_INIT, hw_r[15:8]);
          tneg_r  <= tneg_c;
          tmag_r  <= tmag_c;
          anum_r  <= anum_c;
          state_r <= F_LO;
        end
        F_LO: begin
          crc_t_r <= crc8_byte(crc_t_r, tw_r[7:0]);
          crc_h_r <= crc8_byte(crc_h_r, hw_r[7:0]);
          t_r     <= tneg_r ? 15'sd0 - $signed(tq) : $signed(tq);
          p100_r  <= NUM_W'(anum_r) * HUMI_X100;
          state_r <= F_COMP;
        end
        F_COMP: begin
          c_r     <= c_c;
          state_r <= F_HNUM;
        end
        F_HNUM: begin
          num_r   <= p100_r + (NUM_W'(c_r) <<< 16) - NUM_W'(c_r);
          state_r <= F_HMAG;
        end
        F_HMAG: begin
          hneg_r  <= num_r[NUM_W-1];
          hmag_r  <= hmag_full[MAG_W-1:0];
          state_r <= F_HSUM;
        end
        F_HSUM: begin
          ha_r    <= hmag_r[MAG_W-1:16];
          hs_r    <= 22'(hmag_r[MAG_W-1:16]) + 22'(hmag_r[15:0]);
          state_r <= F_HQUO;
        end
        F_HQUO: begin
          q1_r    <= q1_c;
          state_r <= F_HSCALE;
        end
        F_HSCALE: begin
          h_r     <= hneg_r ? 15'sd0 - $signed(q2) : $signed(q2);
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

[rtl/ssqf_queue.sv]
// Two-entry queue of classified samples between the front and back ends.
// Depends on ssqf_pkg for the record type.
module ssqf_queue import ssqf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  rec_t push_rec,
  output logic pop_valid,
  input  logic pop_ready,
  output rec_t pop_rec
);

  rec_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   fill_r;
  logic              do_push, do_pop;

  assign push_ready = (fill_r != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_rec    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        mem_r[wr_ptr_r] <= push_rec;
        wr_ptr_r        <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

[rtl/ssqf_back.sv]
// Back end: jump checks against the held value, moving-average window and
// bit-serial mean divider, output register. Depends on ssqf_pkg and ssqf_out_if.
module ssqf_back import ssqf_pkg::*; #(
  parameter int WINDOW = 5
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     pop_valid,
  output logic     pop_ready,
  input  rec_t     pop_rec,
  ssqf_out_if.source out_ch
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int TS_W   = TEMP_W + $clog2(WINDOW);
  localparam int HS_W   = HUMI_W + $clog2(WINDOW);
  localparam int DQ_W   = TS_W;
  localparam int STEP_W = $clog2(DQ_W + 1);

  typedef enum logic [1:0] {B_IDLE, B_CHECK, B_DIV, B_EMIT} bstate_t;

  bstate_t state_r;

  rec_t                     rec_r;
  logic signed [TEMP_W-1:0] win_temp_r [WINDOW];
  logic [HUMI_W-1:0]        win_humi_r [WINDOW];
  logic [SLOT_W-1:0]        slot_r;
  logic                     full_r;
  logic signed [TS_W-1:0]   tsum_r;
  logic [HS_W-1:0]          hsum_r;
  logic signed [TEMP_W-1:0] held_temp_r;
  logic [HUMI_W-1:0]        held_humi_r;
  logic                     have_history_r;
  logic [CNT_W-1:0]         dvsr_r, trem_r, hrem_r;
  logic [DQ_W-1:0]          tdq_r, hdq_r;
  logic                     tneg_r;
  logic [STEP_W-1:0]        step_r;
  status_t                  res_status_r;
  logic signed [TEMP_W-1:0] res_temp_r;
  logic [HUMI_W-1:0]        res_humi_r;
  logic                     res_fresh_r;
  logic                     out_valid_r;
  logic signed [TEMP_W-1:0] out_temp_r;
  logic [HUMI_W-1:0]        out_humi_r;
  status_t                  out_status_r;
  logic                     out_fresh_r;

  logic signed [TEMP_W:0]   tdiff;
  logic [TEMP_W:0]          tabs;
  logic signed [HUMI_W:0]   hdiff;
  logic [HUMI_W:0]          habs;
  status_t                  st_c;
  logic signed [TS_W-1:0]   old_t_ext, new_t_ext, tsum_nxt;
  logic [HS_W-1:0]          old_h_ext, hsum_nxt;
  logic [TS_W-1:0]          tsum_abs;
  logic                     wrap;
  logic [SLOT_W-1:0]        slot_nxt;
  logic [CNT_W-1:0]         cnt_nxt;
  logic [CNT_W:0]           ttrial, htrial;
  logic                     tge, hge;
  logic [TEMP_W-1:0]        tquo;
  logic                     emit_go;

  always_comb begin
    tdiff = $signed({rec_r.temp[TEMP_W-1], rec_r.temp})
          - $signed({held_temp_r[TEMP_W-1], held_temp_r});
    tabs  = tdiff[TEMP_W] ? -tdiff : tdiff;
    hdiff = $signed({1'b0, rec_r.humi}) - $signed({1'b0, held_humi_r});
    habs  = hdiff[HUMI_W] ? -hdiff : hdiff;

    if (rec_r.status != ST_OK) begin
      st_c = rec_r.status;
    end else if (have_history_r && tabs > {1'b0, cfg.temp_step_max}) begin
      st_c = ST_TEMP_JUMP;
    end else if (have_history_r && habs > {1'b0, cfg.humi_step_max}) begin
      st_c = ST_HUMI_JUMP;
    end else begin
      st_c = ST_OK;
    end

    old_t_ext = full_r ? TS_W'(win_temp_r[slot_r]) : '0;
    new_t_ext = TS_W'(rec_r.temp);
    tsum_nxt  = tsum_r - old_t_ext + new_t_ext;
    old_h_ext = full_r ? HS_W'(win_humi_r[slot_r]) : '0;
    hsum_nxt  = hsum_r - old_h_ext + HS_W'(rec_r.humi);
    tsum_abs  = tsum_nxt[TS_W-1] ? -tsum_nxt : tsum_nxt;

    wrap     = (slot_r == SLOT_W'(WINDOW - 1));
    slot_nxt = wrap ? '0 : slot_r + 1'b1;
    cnt_nxt  = (full_r || wrap) ? CNT_W'(WINDOW) : CNT_W'(slot_r) + 1'b1;

    ttrial = {trem_r, tdq_r[DQ_W-1]};
    htrial = {hrem_r, hdq_r[DQ_W-1]};
    tge    = ttrial >= {1'b0, dvsr_r};
    hge    = htrial >= {1'b0, dvsr_r};
    tquo   = tdq_r[TEMP_W-1:0];
  end

  assign emit_go            = (state_r == B_EMIT) && (!out_valid_r || out_ch.ready);
  assign pop_ready          = (state_r == B_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.temperature = out_temp_r;
  assign out_ch.humidity    = out_humi_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.fresh       = out_fresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= B_IDLE;
      slot_r         <= '0;
      full_r         <= 1'b0;
      tsum_r         <= '0;
      hsum_r         <= '0;
      held_temp_r    <= '0;
      held_humi_r    <= '0;
      have_history_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !emit_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (pop_valid) begin
            rec_r   <= pop_rec;
            state_r <= B_CHECK;
          end
        end
        B_CHECK: begin
          res_status_r <= st_c;
          if (st_c == ST_OK) begin
            win_temp_r[slot_r] <= rec_r.temp;
            win_humi_r[slot_r] <= rec_r.humi;
            tsum_r  <= tsum_nxt;
            hsum_r  <= hsum_nxt;
            slot_r  <= slot_nxt;
            full_r  <= full_r || wrap;
            dvsr_r  <= cnt_nxt;
            tneg_r  <= tsum_nxt[TS_W-1];
            tdq_r   <= tsum_abs;
            hdq_r   <= DQ_W'(hsum_nxt);
            trem_r  <= '0;
            hrem_r  <= '0;
            step_r  <= STEP_W'(DQ_W);
            state_r <= B_DIV;
          end else begin
            res_temp_r  <= have_history_r ? held_temp_r : '0;
            res_humi_r  <= have_history_r ? held_humi_r : '0;
            res_fresh_r <= 1'b0;
            state_r     <= B_EMIT;
          end
        end
        B_DIV: begin
          if (step_r != '0) begin
            trem_r <= tge ? CNT_W'(ttrial - {1'b0, dvsr_r}) : ttrial[CNT_W-1:0];
            hrem_r <= hge ? CNT_W'(htrial - {1'b0, dvsr_r}) : htrial[CNT_W-1:0];
            tdq_r  <= {tdq_r[DQ_W-2:0], tge};
            hdq_r  <= {hdq_r[DQ_W-2:0], hge};
            step_r <= step_r - 1'b1;
          end else begin
            held_temp_r    <= tneg_r ? 15'sd0 - $signed(tquo) : $signed(tquo);
            held_humi_r    <= hdq_r[HUMI_W-1:0];
            have_history_r <= 1'b1;
            res_temp_r     <= tneg_r ? 15'sd0 - $signed(tquo) : $signed(tquo);
            res_humi_r     <= hdq_r[HUMI_W-1:0];
            res_fresh_r    <= 1'b1;
            state_r        <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (emit_go) begin
            out_valid_r  <= 1'b1;
            out_temp_r   <= res_temp_r;
            out_humi_r   <= res_humi_r;
            out_status_r <= res_status_r;
            out_fresh_r  <= res_fresh_r;
            state_r      <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

[rtl/sensor_sample_qualify_filter_top.sv]
// Top level of the sensor sample qualifier and moving-average filter.
// Holds the register file; depends on ssqf_pkg, ssqf_if, ssqf_front, ssqf_queue, ssqf_back.
//
//   port    | role   | payload                                             | transfer
//   in_ch   | sink   | bus_ok, temp_word, temp_check, humi_word, humi_check | valid & ready
//   out_ch  | source | temperature, humidity, status, fresh                | valid & ready
//   cfg_ch  | sink   | index, data (register write, always ready)          | valid & ready
//
// Front end: its step sequencer takes one frame at a time and takes the next only once the
// last is pushed to the queue. Back end: a rejected sample skips the division, an accepted
// one runs the one-bit-per-cycle mean divider; the next is popped only after an emit.
// Reset is synchronous: registers to defaults, history, sums and window pointer cleared.
// A two-entry queue parts front and back; the output register holds a result until taken.
module sensor_sample_qualify_filter_top import ssqf_pkg::*; #(
  parameter int WINDOW = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  ssqf_in_if.sink     in_ch,
  ssqf_out_if.source  out_ch,
  ssqf_cfg_if.sink    cfg_ch
);

  cfg_t cfg_r;
  logic push_valid, push_ready, pop_valid, pop_ready;
  rec_t push_rec, pop_rec;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_TEMP_MIN:  cfg_r.temp_min      <= $signed(cfg_ch.data[TEMP_W-1:0]);
        CFG_TEMP_MAX:  cfg_r.temp_max      <= $signed(cfg_ch.data[TEMP_W-1:0]);
        CFG_TEMP_STEP: cfg_r.temp_step_max <= cfg_ch.data[TSTEP_W-1:0];
        CFG_HUMI_STEP: cfg_r.humi_step_max <= cfg_ch.data[HSTEP_W-1:0];
      endcase
    end
  end

  ssqf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec)
  );

  ssqf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_rec    (pop_rec)
  );

  ssqf_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_rec   (pop_rec),
    .out_ch    (out_ch)
  );

endmodule

[verif/tb_sensor_sample_qualify_filter_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for sensor_sample_qualify_filter_top: directed frames, then random
// sensor walks mixed with bus, CRC and range faults over several register settings.
// Depends on ssqf_pkg, the ssqf channel interfaces and the block itself.
module tb_sensor_sample_qualify_filter_top;
  import ssqf_pkg::*;

  localparam int     WINDOW        = 5;
  localparam int     CLK_HALF      = 4;
  localparam int     RESET_CYCLES  = 5;
  localparam int     RANDOM_FRAMES = 650;
  localparam int     RANDOM_PHASES = 6;
  localparam int     TAIL_CYCLES   = 40;
  localparam int     MAX_IDLE      = 6;
  localparam int     LOOKAHEAD     = 4;
  localparam longint TIMEOUT_NS    = 64'd5_000_000;

  localparam logic [CHECK_W-1:0] CRC_POLY = 8'h31;
  localparam logic [CHECK_W-1:0] CRC_INIT = 8'hFF;

  localparam int RAW_FULL    = 65535;
  localparam int T_SPAN      = 17500;
  localparam int T_OFFSET    = 4500;
  localparam int H_SPAN      = 12500;
  localparam int H_OFFSET    = 600;
  localparam int COMP_KNEE   = 2500;
  localparam int COMP_COLD   = 15;
  localparam int COMP_MILD   = -3;
  localparam int COMP_WARM   = 8;
  localparam int COMP_SCALE  = 100;
  localparam int T_LOW       = -4500;
  localparam int T_HIGH      = 13000;
  localparam int H_MAX       = 10000;
  localparam int TSTEP_MAX   = 17500;
  localparam int HSTEP_MAX   = 10000;

  localparam int RST_TEMP_MIN  = -2500;
  localparam int RST_TEMP_MAX  = 3000;
  localparam int RST_TEMP_STEP = 500;
  localparam int RST_HUMI_STEP = 1000;

  typedef struct {
    logic               bus_ok;
    logic [WORD_W-1:0]  temp_word;
    logic [CHECK_W-1:0] temp_check;
    logic [WORD_W-1:0]  humi_word;
    logic [CHECK_W-1:0] humi_check;
  } sensor_frame_t;

  typedef struct {
    logic signed [TEMP_W-1:0] temperature;
    logic [HUMI_W-1:0]        humidity;
    status_t                  status;
    logic                     fresh;
  } filter_result_t;

  typedef struct {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst_n;

  ssqf_in_if  in_ch ();
  ssqf_out_if out_ch ();
  ssqf_cfg_if cfg_ch ();

  sensor_sample_qualify_filter_top #(.WINDOW(WINDOW)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #(CLK_HALF) clk = ~clk;

  int temp_floor   = RST_TEMP_MIN;
  int temp_ceiling = RST_TEMP_MAX;
  int temp_slew    = RST_TEMP_STEP;
  int humi_slew    = RST_HUMI_STEP;

  int temp_win [WINDOW];
  int humi_win [WINDOW];
  int win_slot     = 0;
  bit win_full     = 1'b0;
  int temp_total   = 0;
  int humi_total   = 0;
  int held_temp    = 0;
  int held_humi    = 0;
  bit have_history = 1'b0;

  sensor_frame_t  frames_pending [$];
  filter_result_t readings_due [$];
  reg_write_t     writes_pending [$];

  sensor_frame_t  taken_frame;
  sensor_frame_t  next_frame;
  filter_result_t want;
  reg_write_t     next_write;

  bit sender_steady   = 1'b0;
  bit receiver_steady = 1'b0;
  int send_gap;
  int take_stall;
  int drawn_stall;

  int mismatches    = 0;
  int frames_taken  = 0;
  int fresh_seen    = 0;
  int settings_used = 0;
  int status_seen [8];

  function automatic logic [CHECK_W-1:0] frame_crc(input logic [WORD_W-1:0] word);
    logic [CHECK_W-1:0] acc;
    acc = CRC_INIT;
    for (int b = 1; b >= 0; b--) begin
      acc ^= word[b*8 +: 8];
      for (int i = 0; i < 8; i++) begin
        acc = acc[CHECK_W-1] ? ((acc << 1) ^ CRC_POLY) : (acc << 1);
      end
    end
    return acc;
  endfunction

  function automatic longint comp_numerator(input longint t);
    if (t < 0) begin
      return COMP_COLD * t;
    end else if (t < COMP_KNEE) begin
      return COMP_MILD * t;
    end
    return COMP_WARM * (t - COMP_KNEE);
  endfunction

  function automatic longint abs_gap(input longint a, input longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic longint fit(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] index,
                                         input logic [CFG_DATA_W-1:0] data);
    case (index)
      CFG_TEMP_MIN:  temp_floor   = int'($signed(data[TEMP_W-1:0]));
      CFG_TEMP_MAX:  temp_ceiling = int'($signed(data[TEMP_W-1:0]));
      CFG_TEMP_STEP: temp_slew    = int'(data[TSTEP_W-1:0]);
      CFG_HUMI_STEP: humi_slew    = int'(data[HSTEP_W-1:0]);
      default: ;
    endcase
  endfunction

  function automatic filter_result_t qualify_frame(input sensor_frame_t f);
    filter_result_t r;
    longint         t;
    longint         h;
    longint         num;
    int             count;
    status_t        st;
    st = ST_OK;
    t  = 0;
    h  = 0;
    if (!f.bus_ok) begin
      st = ST_BUS;
    end else if (frame_crc(f.temp_word) != f.temp_check) begin
      st = ST_TEMP_CRC;
    end else if (frame_crc(f.humi_word) != f.humi_check) begin
      st = ST_HUMI_CRC;
    end
    if (st == ST_OK) begin
      t = (longint'(T_SPAN) * longint'(f.temp_word) - longint'(T_OFFSET) * RAW_FULL)
          / RAW_FULL;
      num = (longint'(H_SPAN) * longint'(f.humi_word) - longint'(H_OFFSET) * RAW_FULL)
            * COMP_SCALE + comp_numerator(t) * RAW_FULL;
      h = num / (longint'(RAW_FULL) * COMP_SCALE);
      if (t < temp_floor || t > temp_ceiling) begin
        st = ST_TEMP_RANGE;
      end else if (h < 0 || h > H_MAX) begin
        st = ST_HUMI_RANGE;
      end else if (have_history && abs_gap(t, held_temp) > temp_slew) begin
        st = ST_TEMP_JUMP;
      end else if (have_history && abs_gap(h, held_humi) > humi_slew) begin
        st = ST_HUMI_JUMP;
      end
    end
    r.status = st;
    r.fresh  = 1'b0;
    if (st == ST_OK) begin
      if (win_full) begin
        temp_total -= temp_win[win_slot];
        humi_total -= humi_win[win_slot];
      end
      temp_win[win_slot] = int'(t);
      humi_win[win_slot] = int'(h);
      temp_total += int'(t);
      humi_total += int'(h);
      win_slot = (win_slot + 1) % WINDOW;
      if (win_slot == 0) begin
        win_full = 1'b1;
      end
      count = win_full ? WINDOW : win_slot;
      held_temp    = temp_total / count;
      held_humi    = humi_total / count;
      have_history = 1'b1;
      r.fresh      = 1'b1;
    end
    r.temperature = have_history ? TEMP_W'(held_temp) : '0;
    r.humidity    = have_history ? HUMI_W'(held_humi) : '0;
    return r;
  endfunction

  function automatic int temp_to_raw(input longint centi);
    return int'(fit(((centi + T_OFFSET) * RAW_FULL + T_SPAN / 2) / T_SPAN, 0, RAW_FULL));
  endfunction

  function automatic int humi_to_raw(input longint centi, input longint temp_centi);
    longint raw;
    raw = (((centi + H_OFFSET) * COMP_SCALE - comp_numerator(temp_centi)) * RAW_FULL
           + H_SPAN * COMP_SCALE / 2) / (H_SPAN * COMP_SCALE);
    return int'(fit(raw, 0, RAW_FULL));
  endfunction

  function automatic int rand_offset(input int span);
    return $urandom_range(0, 1) ? int'($urandom_range(0, span)) : -int'($urandom_range(0, span));
  endfunction

  function automatic void queue_frame(input logic bus_ok, input int temp_raw, input int humi_raw,
                                      input logic [CHECK_W-1:0] temp_err,
                                      input logic [CHECK_W-1:0] humi_err);
    sensor_frame_t f;
    f.bus_ok     = bus_ok;
    f.temp_word  = WORD_W'(temp_raw);
    f.humi_word  = WORD_W'(humi_raw);
    f.temp_check = frame_crc(f.temp_word) ^ temp_err;
    f.humi_check = frame_crc(f.humi_word) ^ humi_err;
    frames_pending.push_back(f);
  endfunction

  function automatic void queue_clean_frame(input longint temp_centi, input longint humi_centi);
    queue_frame(1'b1, temp_to_raw(temp_centi), humi_to_raw(humi_centi, temp_centi), '0, '0);
  endfunction

  task automatic wait_drained();
    while (frames_pending.size() != 0 || in_ch.valid || readings_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic program_limits(input int tmin, input int tmax, input int tstep, input int hstep);
    reg_write_t w;
    w.index = CFG_TEMP_MIN;
    w.data  = CFG_DATA_W'(tmin);
    w.data[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
    writes_pending.push_back(w);
    w.index = CFG_TEMP_MAX;
    w.data  = CFG_DATA_W'(tmax);
    w.data[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
    writes_pending.push_back(w);
    w.index = CFG_TEMP_STEP;
    w.data  = CFG_DATA_W'(tstep);
    w.data[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
    writes_pending.push_back(w);
    w.index = CFG_HUMI_STEP;
    w.data  = CFG_DATA_W'(hstep);
    w.data[CFG_DATA_W-1 -: 2] = 2'($urandom_range(0, 3));
    writes_pending.push_back(w);
    while (writes_pending.size() != 0 || cfg_ch.valid) begin
      @(negedge clk);
    end
    settings_used++;
  endtask

  task automatic run_walk_phase(input int frames);
    int     pick;
    longint temp_aim;
    longint humi_aim;
    longint temp_try;
    longint humi_try;
    longint lo;
    longint hi;
    temp_aim = held_temp;
    humi_aim = held_humi;
    lo = fit(temp_floor, T_LOW, T_HIGH);
    hi = fit(temp_ceiling, T_LOW, T_HIGH);
    sender_steady   = ($urandom_range(0, 3) == 0);
    receiver_steady = ($urandom_range(0, 3) == 0);
    for (int n = 0; n < frames; n++) begin
      while (frames_pending.size() >= LOOKAHEAD) begin
        @(negedge clk);
      end
      if (n == frames / 2 && $urandom_range(0, 1)) begin
        wait_drained();
        sender_steady = ~sender_steady;
      end
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        temp_aim = temp_aim + rand_offset(temp_slew / 3);
        humi_aim = humi_aim + rand_offset(humi_slew / 3);
        if (lo <= hi) begin
          temp_aim = fit(temp_aim, lo, hi);
        end
        humi_aim = fit(humi_aim, 0, H_MAX);
        temp_try = temp_aim;
        humi_try = humi_aim;
        if (pick < 6) begin
          temp_try = temp_aim + (temp_slew + int'($urandom_range(1, 1500)))
                     * ($urandom_range(0, 1) ? 1 : -1);
        end else if (pick < 12) begin
          humi_try = humi_aim + (humi_slew + int'($urandom_range(1, 1500)))
                     * ($urandom_range(0, 1) ? 1 : -1);
        end
        queue_clean_frame(temp_try, humi_try);
      end else if (pick < 84) begin
        queue_frame(1'b0, $urandom_range(0, RAW_FULL), $urandom_range(0, RAW_FULL),
                    CHECK_W'($urandom_range(0, 255)), CHECK_W'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        queue_frame(1'b1, $urandom_range(0, RAW_FULL), $urandom_range(0, RAW_FULL),
                    CHECK_W'($urandom_range(1, 255)), CHECK_W'($urandom_range(0, 255)));
      end else if (pick < 94) begin
        queue_frame(1'b1, temp_to_raw(temp_aim), humi_to_raw(humi_aim, temp_aim),
                    '0, CHECK_W'($urandom_range(1, 255)));
      end else begin
        queue_frame(1'b1, $urandom_range(0, RAW_FULL), $urandom_range(0, RAW_FULL), '0, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken_frame.bus_ok     = in_ch.bus_ok;
        taken_frame.temp_word  = in_ch.temp_word;
        taken_frame.temp_check = in_ch.temp_check;
        taken_frame.humi_word  = in_ch.humi_word;
        taken_frame.humi_check = in_ch.humi_check;
        readings_due.push_back(qualify_frame(taken_frame));
        frames_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap != 0) begin
          in_ch.valid <= 1'b0;
          send_gap    <= send_gap - 1;
        end else if (frames_pending.size() != 0) begin
          next_frame = frames_pending.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.bus_ok     <= next_frame.bus_ok;
          in_ch.temp_word  <= next_frame.temp_word;
          in_ch.temp_check <= next_frame.temp_check;
          in_ch.humi_word  <= next_frame.humi_word;
          in_ch.humi_check <= next_frame.humi_check;
          send_gap         <= sender_steady ? 0 : $urandom_range(0, MAX_IDLE);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      take_stall   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (readings_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got temp %0d humi %0d status %0d fresh %0b",
                   $time, out_ch.temperature, out_ch.humidity, out_ch.status, out_ch.fresh);
          mismatches++;
        end else begin
          want = readings_due.pop_front();
          if (out_ch.temperature !== want.temperature) begin
            $display("%0t: temperature expected %0d got %0d", $time, want.temperature,
                     out_ch.temperature);
            mismatches++;
          end
          if (out_ch.humidity !== want.humidity) begin
            $display("%0t: humidity expected %0d got %0d", $time, want.humidity, out_ch.humidity);
            mismatches++;
          end
          if (out_ch.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, out_ch.status);
            mismatches++;
          end
          if (out_ch.fresh !== want.fresh) begin
            $display("%0t: fresh expected %0b got %0b", $time, want.fresh, out_ch.fresh);
            mismatches++;
          end
          status_seen[want.status]++;
          if (want.fresh) begin
            fresh_seen++;
          end
        end
        drawn_stall = receiver_steady ? 0 : $urandom_range(0, MAX_IDLE);
        take_stall   <= drawn_stall;
        out_ch.ready <= (drawn_stall == 0);
      end else if (take_stall != 0) begin
        take_stall   <= take_stall - 1;
        out_ch.ready <= (take_stall == 1);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_ch.valid <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        apply_register(cfg_ch.index, cfg_ch.data);
      end
      if (!cfg_ch.valid || cfg_ch.ready) begin
        if (writes_pending.size() != 0) begin
          next_write = writes_pending.pop_front();
          cfg_ch.valid <= 1'b1;
          cfg_ch.index <= next_write.index;
          cfg_ch.data  <= next_write.data;
        end else begin
          cfg_ch.valid <= 1'b0;
        end
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.bus_ok     = 1'b0;
    in_ch.temp_word  = '0;
    in_ch.temp_check = '0;
    in_ch.humi_word  = '0;
    in_ch.humi_check = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset limits: faults with no history, then build and wrap the window
    queue_frame(1'b0, RAW_FULL, RAW_FULL, '1, '1);
    queue_frame(1'b1, temp_to_raw(2000), humi_to_raw(5000, 2000), 8'h01, '0);
    queue_frame(1'b1, temp_to_raw(2000), humi_to_raw(5000, 2000), '0, 8'h80);
    queue_frame(1'b1, 0, humi_to_raw(5000, 2000), '0, '0);
    queue_frame(1'b1, RAW_FULL, humi_to_raw(5000, 2000), '0, '0);
    queue_frame(1'b1, temp_to_raw(2000), 0, '0, '0);
    queue_frame(1'b1, temp_to_raw(2000), RAW_FULL, '0, '0);
    queue_clean_frame(2000, 5000);
    queue_clean_frame(2800, 5000);
    queue_clean_frame(2000, 6500);
    queue_frame(1'b0, temp_to_raw(2000), humi_to_raw(5000, 2000), '0, '0);
    for (int k = 1; k <= 6; k++) begin
      queue_clean_frame(2000 + 50 * k, 5000 - 40 * k);
    end
    wait_drained();

    program_limits(T_LOW, T_HIGH, TSTEP_MAX, HSTEP_MAX);
    queue_frame(1'b1, 0, humi_to_raw(3000, T_LOW), '0, '0);
    queue_frame(1'b1, RAW_FULL, humi_to_raw(3000, T_HIGH), '0, '0);
    queue_clean_frame(2000, H_MAX);
    queue_clean_frame(2000, 0);
    wait_drained();

    // inverted bounds reject every temperature
    program_limits(T_HIGH, T_LOW, TSTEP_MAX, HSTEP_MAX);
    queue_clean_frame(0, 4000);
    queue_clean_frame(2000, 4000);
    wait_drained();

    program_limits(T_LOW, T_HIGH, 0, 0);
    queue_clean_frame(held_temp, held_humi);
    queue_clean_frame(held_temp + 100, held_humi);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: program_limits(T_LOW, T_HIGH, TSTEP_MAX, HSTEP_MAX);
        1: program_limits(int'(fit(held_temp - int'($urandom_range(200, 4000)), T_LOW, T_HIGH)),
                          int'(fit(held_temp + int'($urandom_range(200, 4000)), T_LOW, T_HIGH)),
                          $urandom_range(5, 40), $urandom_range(5, 40));
        default: program_limits(
                   int'(fit(held_temp - int'($urandom_range(200, 4000)), T_LOW, T_HIGH)),
                   int'(fit(held_temp + int'($urandom_range(200, 4000)), T_LOW, T_HIGH)),
                   $urandom_range(50, 3000), $urandom_range(50, 3000));
      endcase
      run_walk_phase(RANDOM_FRAMES / RANDOM_PHASES);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Run covered %0d frames under %0d register settings, %0d fresh results.",
             frames_taken, settings_used, fresh_seen);
    $display("Outcomes ok %0d bus %0d crc %0d/%0d range %0d/%0d jump %0d/%0d",
             status_seen[ST_OK], status_seen[ST_BUS], status_seen[ST_TEMP_CRC],
             status_seen[ST_HUMI_CRC], status_seen[ST_TEMP_RANGE], status_seen[ST_HUMI_RANGE],
             status_seen[ST_TEMP_JUMP], status_seen[ST_HUMI_JUMP]);
    if (mismatches == 0 && readings_due.size() == 0) begin
      $display("PASS sensor_sample_qualify_filter_top");
    end else begin
      $display("FAIL sensor_sample_qualify_filter_top");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL sensor_sample_qualify_filter_top");
    $finish;
  end

endmodule

[filelist.f]
rtl/ssqf_pkg.sv
rtl/ssqf_if.sv
rtl/ssqf_front.sv
rtl/ssqf_queue.sv
rtl/ssqf_back.sv
rtl/sensor_sample_qualify_filter_top.sv
verif/tb_sensor_sample_qualify_filter_top.sv
